@@ src/cilp_pkg.sv @@
// Shared types and constants for the C integer literal parser.
// No dependencies. Used by the front, queue and back modules.
package cilp_pkg;

  // Character classes that the front end hands to the back end.
  typedef enum logic [3:0] {
    CC_SPACE,   // space, tab, LF, VT, FF, CR
    CC_PLUS,
    CC_MINUS,
    CC_DIGIT,   // 0..9, digit value carried alongside
    CC_HEXA,    // A..F in either case, value 10..15
    CC_X,
    CC_L,
    CC_U,
    CC_OTHER    // terminator or any stray character
  } char_class_t;

  // One classified character word as it sits in the queue.
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  dig;
    logic        last;
  } cls_word_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    cls_word_t word;
  } queue_head_t;

  // Digit value that names binary after a leading zero ("0b").
  localparam logic [3:0] DIG_B = 4'd11;

endpackage

@@ src/cilp_ifs.sv @@
// Valid/ready channel interfaces for the C integer literal parser.
// Depends on nothing; the top level, the front end and the back end use them.
interface cilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cilp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        digit_error;

  modport source (output valid, output value, output digit_error, input ready);
  modport sink   (input valid, input value, input digit_error, output ready);
endinterface

@@ src/cilp_front.sv @@
// Front end: accepts character words and classifies them for the queue.
// Depends on cilp_pkg and cilp_ifs.
module cilp_front (
  cilp_in_if.sink             in_chan,
  input  logic                q_full,
  output logic                q_push,
  output cilp_pkg::cls_word_t q_word
);

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] CH_UL    = 8'd76;
  localparam logic [7:0] CH_UU    = 8'd85;
  localparam logic [7:0] CH_UX    = 8'd88;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LZ    = 8'd122;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] HEX_OFS  = 8'd55;  // 'A' - 10

  logic [7:0] ch;
  logic [7:0] up;
  logic [7:0] dsub;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;
  assign ch            = in_chan.char_code;

  // fold lower case onto upper case
  assign up = (ch >= CH_LA && ch <= CH_LZ) ? ch - CASE_OFS : ch;

  // classify
  always_comb begin
    q_word.last = in_chan.last_char;
    dsub        = 8'd0;
    q_word.dig  = 4'd0;
    if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
      q_word.cls = cilp_pkg::CC_SPACE;
    end else if (ch == CH_PLUS) begin
      q_word.cls = cilp_pkg::CC_PLUS;
    end else if (ch == CH_MINUS) begin
      q_word.cls = cilp_pkg::CC_MINUS;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      q_word.cls = cilp_pkg::CC_DIGIT;
      dsub       = ch - CH_0;
      q_word.dig = dsub[3:0];
    end else if (up >= CH_UA && up <= CH_UF) begin
      q_word.cls = cilp_pkg::CC_HEXA;
      dsub       = up - HEX_OFS;
      q_word.dig = dsub[3:0];
    end else if (up == CH_UX) begin
      q_word.cls = cilp_pkg::CC_X;
    end else if (up == CH_UL) begin
      q_word.cls = cilp_pkg::CC_L;
    end else if (up == CH_UU) begin
      q_word.cls = cilp_pkg::CC_U;
    end else begin
      q_word.cls = cilp_pkg::CC_OTHER;
    end
  end

endmodule

@@ src/cilp_queue.sv @@
// Short queue of classified words between the front and back ends.
// Depends on cilp_pkg.
module cilp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cilp_pkg::cls_word_t   push_word,
  output logic                  full,
  input  logic                  pop,
  output cilp_pkg::queue_head_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cilp_pkg::cls_word_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.word  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/cilp_back.sv @@
// Back end: runs the literal parser state machine over classified words
// and holds the finished result word. Depends on cilp_pkg and cilp_ifs.
module cilp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cilp_pkg::queue_head_t head,
  output logic                  pop,
  cilp_out_if.source            out_chan
);

  typedef enum logic [2:0] {
    PH_SPACE, PH_FIRST, PH_ZERO, PH_DEC, PH_BASED, PH_SUFFIX, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {RX_DEC, RX_OCT, RX_HEX, RX_BIN} radix_t;

  phase_t      phase_r,  phase_nxt;
  radix_t      radix_r,  radix_nxt;
  logic [63:0] acc_r,    acc_nxt;
  logic        neg_r,    neg_nxt;
  logic [1:0]  lcnt_r,   lcnt_nxt;
  logic        uns_r,    uns_nxt;
  logic        err_r,    err_nxt;

  // held result record
  logic        rec_valid_r, rec_valid_nxt;
  logic [63:0] rec_acc_r;
  logic        rec_neg_r, rec_cast_r, rec_uns_r, rec_err_r;

  logic        first_go, dec_go, suffix_go, based_go;
  logic        is_digit, is_num;
  logic [3:0]  dig;
  logic        take_last;
  logic [63:0] neg_val, cast_val;

  assign pop       = head.valid && (!head.word.last || !rec_valid_r || out_chan.ready);
  assign take_last = pop && head.word.last;
  assign dig       = head.word.dig;
  assign is_digit  = (head.word.cls == cilp_pkg::CC_DIGIT);
  assign is_num    = is_digit || (head.word.cls == cilp_pkg::CC_HEXA);

  // next parser state for the word at the queue head
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    lcnt_nxt  = lcnt_r;
    uns_nxt   = uns_r;
    err_nxt   = err_r;
    first_go  = 1'b0;
    dec_go    = 1'b0;
    suffix_go = 1'b0;
    based_go  = 1'b0;

    unique case (phase_r)
      PH_SPACE: begin
        if (head.word.cls == cilp_pkg::CC_SPACE) begin
          phase_nxt = PH_SPACE;
        end else if (head.word.cls == cilp_pkg::CC_PLUS ||
                     head.word.cls == cilp_pkg::CC_MINUS) begin
          neg_nxt   = (head.word.cls == cilp_pkg::CC_MINUS);
          phase_nxt = PH_FIRST;
        end else begin
          first_go = 1'b1;
        end
      end
      PH_FIRST: first_go = 1'b1;
      PH_ZERO: begin
        phase_nxt = PH_BASED;
        if (head.word.cls == cilp_pkg::CC_X) begin
          radix_nxt = RX_HEX;
        end else if (head.word.cls == cilp_pkg::CC_HEXA && dig == cilp_pkg::DIG_B) begin
          radix_nxt = RX_BIN;
        end else begin
          based_go = 1'b1;
        end
      end
      PH_DEC:    dec_go    = 1'b1;
      PH_BASED:  based_go  = 1'b1;
      PH_SUFFIX: suffix_go = 1'b1;
      default:   phase_nxt = PH_DONE;
    endcase

    // first character after whitespace and sign
    if (first_go) begin
      if (is_digit && dig == 4'd0) begin
        radix_nxt = RX_OCT;
        phase_nxt = PH_ZERO;
      end else begin
        radix_nxt = RX_DEC;
        phase_nxt = PH_DEC;
        dec_go    = 1'b1;
      end
    end

    // decimal digits: acc * 10 + d as two shifted adds
    if (dec_go) begin
      if (is_digit) begin
        acc_nxt = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, dig};
      end else begin
        phase_nxt = PH_SUFFIX;
        suffix_go = 1'b1;
      end
    end

    // L / U suffixes, L count saturates
    if (suffix_go) begin
      if (head.word.cls == cilp_pkg::CC_L) begin
        if (lcnt_r != 2'd3) begin
          lcnt_nxt = lcnt_r + 2'd1;
        end
      end else if (head.word.cls == cilp_pkg::CC_U) begin
        uns_nxt = 1'b1;
      end else begin
        phase_nxt = PH_DONE;
      end
    end

    // octal, hex and binary digits; digit is below the base so OR acts as add
    if (based_go) begin
      if (!is_num) begin
        phase_nxt = PH_DONE;
      end else begin
        unique case (radix_r)
          RX_HEX: acc_nxt = {acc_r[59:0], dig};
          RX_BIN: begin
            if (dig[3:1] != 3'd0) begin
              err_nxt   = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              acc_nxt = {acc_r[62:0], dig[0]};
            end
          end
          default: begin
            if (dig[3]) begin
              err_nxt   = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              acc_nxt = {acc_r[60:0], dig[2:0]};
            end
          end
        endcase
      end
    end

    // result word handshake
    if (take_last) begin
      rec_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  // state and result record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      radix_r     <= RX_DEC;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      lcnt_r      <= '0;
      uns_r       <= 1'b0;
      err_r       <= 1'b0;
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      if (take_last) begin
        rec_acc_r  <= acc_nxt;
        rec_neg_r  <= neg_nxt;
        rec_cast_r <= (radix_nxt == RX_DEC) && (lcnt_nxt == 2'd0);
        rec_uns_r  <= uns_nxt;
        rec_err_r  <= err_nxt;
        phase_r    <= PH_SPACE;
        radix_r    <= RX_DEC;
        acc_r      <= '0;
        neg_r      <= 1'b0;
        lcnt_r     <= '0;
        uns_r      <= 1'b0;
        err_r      <= 1'b0;
      end else if (pop) begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        lcnt_r  <= lcnt_nxt;
        uns_r   <= uns_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // negate, then cast to 32 bits when there is no L on a decimal literal
  assign neg_val  = rec_neg_r ? (~rec_acc_r) + 64'd1 : rec_acc_r;
  assign cast_val = rec_cast_r ?
                    {{32{neg_val[31] & ~rec_uns_r}}, neg_val[31:0]} : neg_val;

  assign out_chan.valid       = rec_valid_r;
  assign out_chan.value       = rec_err_r ? 64'd0 : cast_val;
  assign out_chan.digit_error = rec_err_r;

endmodule

@@ src/c_integer_literal_parser_top.sv @@
// C integer literal parser, one character word per clock. The front end
// classifies each accepted character and pushes it into a DEPTH-entry queue;
// the back end's parser state machine takes one queued word per cycle, so the
// sustained rate is one character per cycle. A result word is registered and
// appears the cycle after the back end consumes the character marked last;
// input stalls only when the queue fills behind a held, untaken result.
// Depends on cilp_pkg, cilp_ifs, cilp_front, cilp_queue and cilp_back.
module c_integer_literal_parser_top #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cilp_in_if.sink     in_chan,
  cilp_out_if.source  out_chan
);

  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  cilp_pkg::cls_word_t   q_word;
  cilp_pkg::queue_head_t q_head;

  cilp_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_word  (q_word)
  );

  cilp_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  cilp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

@@ src/cilp_checker.sv @@
// Port-level checks on the C integer literal parser's result channel.
// Bound to c_integer_literal_parser_top; depends on cilp_ifs.
module cilp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic        out_digit_error
);

  // result word stays offered until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // stalled result word holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_digit_error))
    else $error("stalled result word changed");

  // a digit error forces the value to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_error |-> out_value == 64'd0)
    else $error("value not zero on digit error");

  // no result word right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result word offered straight out of reset");

endmodule

bind c_integer_literal_parser_top cilp_checker u_cilp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_value       (out_chan.value),
  .out_digit_error (out_chan.digit_error)
);
